FILE: rtl/rfhd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfhd_pkg
// Shared types, constants and helpers of the RPC frame header decoder.
// ----------------------------------------------------------------------------
package rfhd_pkg;

	localparam int HEADER_BYTES = 16;
	localparam int POS_W        = $clog2(HEADER_BYTES);
	localparam int POS_FLAG     = 2;
	localparam int POS_STATUS   = 3;
	localparam int POS_ID_END   = 12;
	localparam int POS_LAST     = HEADER_BYTES - 1;

	localparam int QUEUE_DEPTH  = 2;

	localparam int MAX_BODY_W   = 31;
	localparam int SER_W        = 5;
	localparam int CFG_DATA_W   = MAX_BODY_W;

	localparam logic [15:0]           MAGIC_VALUE    = 16'hdabb;
	localparam int                    REQ_BIT        = 7;
	localparam int                    TWOWAY_BIT     = 6;
	localparam int                    EVENT_BIT      = 5;
	localparam logic [7:0]            STATUS_OK      = 8'd20;
	localparam logic [MAX_BODY_W-1:0] MAX_BODY_RESET = 31'd16777216;
	localparam logic [SER_W-1:0]      SER_ID_RESET   = 5'd2;

	localparam int OUT_BITS   = 3 + 3 + 64 + 31 + 8 + 1;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic {
		CFG_MAX_BODY = 1'b0,
		CFG_SER_ID   = 1'b1
	} cfg_index_t;

	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_MAGIC      = 3'd1,
		ERR_SERIALIZER = 3'd2,
		ERR_BODY_LEN   = 3'd3,
		ERR_STATUS     = 3'd4
	} err_code_t;

	typedef enum logic [2:0] {
		KIND_RESPONSE      = 3'd0,
		KIND_REQUEST       = 3'd1,
		KIND_ONEWAY        = 3'd2,
		KIND_EXCEPTION     = 3'd3,
		KIND_HEARTBEAT_REQ = 3'd4,
		KIND_HEARTBEAT_RSP = 3'd5
	} msg_kind_t;

	typedef struct packed {
		logic [15:0] magic;
		logic [7:0]  flags;
		logic [7:0]  status;
		logic [63:0] call_id;
		logic [31:0] body;
	} hdr_rec_t;

	function automatic logic status_valid(input logic [7:0] s);
		logic ok;
		case (s)
			8'd20, 8'd30, 8'd31, 8'd40, 8'd50,
			8'd60, 8'd70, 8'd80, 8'd90, 8'd100: ok = 1'b1;
			default:                            ok = 1'b0;
		endcase
		return ok;
	endfunction

endpackage

FILE: rtl/rpc_frame_header_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_frame_header_decoder_unit
// Decodes a 16-byte RPC frame header streamed one byte per beat.
// ----------------------------------------------------------------------------
// Throughput: one header byte per cycle unless the intake stalls, one result beat per 16 bytes.
// The result beat is registered in the check stage after the header record has
//   passed through the record queue.
// The intake stalls only on a last byte while the record queue is full.
// Reset clears byte position, queue and output valid; config registers take defaults.
module rpc_frame_header_decoder_unit import rfhd_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,  // header_byte [7:0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// error_code [2:0], message_kind [5:3], call_id [69:6],
	// body_length [100:70], response_status [108:101], has_status [109]
	output logic [OUT_DATA_W-1:0] m_tdata
);

	hdr_rec_t push_rec;
	hdr_rec_t pop_rec;
	logic     q_push;
	logic     q_pop;
	logic     q_full;
	logic     q_empty;

	rfhd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_rec    (push_rec)
	);

	rfhd_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_rec (push_rec),
		.full     (q_full),
		.pop      (q_pop),
		.pop_rec  (pop_rec),
		.empty    (q_empty)
	);

	rfhd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_empty   (q_empty),
		.q_rec     (pop_rec),
		.q_pop     (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("record pushed into full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("record popped from empty queue");

	a_error_clears_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[2:0] != ERR_NONE)) |-> (m_tdata[109:3] == '0))
		else $error("error result carries nonzero fields");

	a_status_only_responses: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[109]) |->
			((m_tdata[5:3] == KIND_RESPONSE) || (m_tdata[5:3] == KIND_EXCEPTION) ||
			 (m_tdata[5:3] == KIND_HEARTBEAT_RSP)))
		else $error("status flagged on a non-response kind");

endmodule

FILE: rtl/rfhd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfhd_front
// Byte intake: tracks the header position and assembles one header record.
// ----------------------------------------------------------------------------
module rfhd_front import rfhd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // header_byte [7:0]
	input  logic       q_full,
	output logic       q_push,
	output hdr_rec_t   q_rec
);

	logic [POS_W-1:0] pos_q;
	logic [15:0]      magic_q;
	logic [7:0]       flags_q;
	logic [7:0]       status_q;
	logic [63:0]      id_q;
	logic [23:0]      len_q;
	logic             accept;
	logic             last;

	assign last     = (pos_q == POS_W'(POS_LAST));
	assign s_tready = !last || !q_full;
	assign accept   = s_tvalid && s_tready;
	assign q_push   = accept && last;

	always_comb begin
		q_rec.magic   = magic_q;
		q_rec.flags   = flags_q;
		q_rec.status  = status_q;
		q_rec.call_id = id_q;
		q_rec.body    = {len_q, s_tdata};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (last) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	// shift each byte but the last into the field it belongs to
	always_ff @(posedge clk) begin
		if (accept) begin
			if (pos_q < POS_W'(POS_FLAG)) begin
				magic_q <= {magic_q[7:0], s_tdata};
			end else if (pos_q == POS_W'(POS_FLAG)) begin
				flags_q <= s_tdata;
			end else if (pos_q == POS_W'(POS_STATUS)) begin
				status_q <= s_tdata;
			end else if (pos_q < POS_W'(POS_ID_END)) begin
				id_q <= {id_q[55:0], s_tdata};
			end else if (!last) begin
				len_q <= {len_q[15:0], s_tdata};
			end
		end
	end

endmodule

FILE: rtl/rfhd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfhd_queue
// Short FIFO of header records between intake and check stage.
// ----------------------------------------------------------------------------
module rfhd_queue import rfhd_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  hdr_rec_t push_rec,
	output logic     full,
	input  logic     pop,
	output hdr_rec_t pop_rec,
	output logic     empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	hdr_rec_t       mem_q [DEPTH];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign pop_rec = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_rec;
		end
	end

endmodule

FILE: rtl/rfhd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfhd_back
// Check stage: validates a header record, classifies it and holds the result.
// ----------------------------------------------------------------------------
module rfhd_back import rfhd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  q_empty,
	input  hdr_rec_t              q_rec,
	output logic                  q_pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata
);

	logic [MAX_BODY_W-1:0] max_body_q;
	logic [SER_W-1:0]      ser_id_q;
	logic                  valid_q;
	logic [OUT_DATA_W-1:0] data_q;

	err_code_t             err;
	msg_kind_t             kind;
	logic                  has_status;
	logic [OUT_DATA_W-1:0] result;

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign q_pop    = !q_empty && (!valid_q || m_tready);

	always_comb begin
		err        = ERR_NONE;
		kind       = KIND_RESPONSE;
		has_status = 1'b0;
		if (q_rec.magic != MAGIC_VALUE) begin
			err = ERR_MAGIC;
		end else if (q_rec.flags[SER_W-1:0] != ser_id_q) begin
			err = ERR_SERIALIZER;
		end else if (q_rec.body[31] || (q_rec.body[30:0] > max_body_q)) begin
			err = ERR_BODY_LEN;
		end else if (q_rec.flags[REQ_BIT]) begin
			if (q_rec.flags[EVENT_BIT]) begin
				kind = KIND_HEARTBEAT_REQ;
			end else if (q_rec.flags[TWOWAY_BIT]) begin
				kind = KIND_REQUEST;
			end else begin
				kind = KIND_ONEWAY;
			end
		end else if (!status_valid(q_rec.status)) begin
			err = ERR_STATUS;
		end else begin
			has_status = 1'b1;
			if (q_rec.status != STATUS_OK) begin
				kind = KIND_EXCEPTION;
			end else if (q_rec.flags[EVENT_BIT]) begin
				kind = KIND_HEARTBEAT_RSP;
			end else begin
				kind = KIND_RESPONSE;
			end
		end

		result      = '0;
		result[2:0] = err;
		if (err == ERR_NONE) begin
			result[5:3]     = kind;
			result[69:6]    = q_rec.call_id;
			result[100:70]  = q_rec.body[30:0];
			result[108:101] = has_status ? q_rec.status : 8'd0;
			result[109]     = has_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_body_q <= MAX_BODY_RESET;
			ser_id_q   <= SER_ID_RESET;
			valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index_t'(cfg_index))
					CFG_MAX_BODY: max_body_q <= cfg_data;
					CFG_SER_ID:   ser_id_q   <= cfg_data[SER_W-1:0];
					default:      ;
				endcase
			end
			if (q_pop) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			data_q <= result;
		end
	end

endmodule
